/* src/gic_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_pkg: shared types and constants of the gamepad input conditioner
// Sizes, direction codes and the payload structs of both channels.
// ----------------------------------------------------------------------------
package gic_pkg;

   localparam int NUM_BUTTONS = 18;
   localparam int NUM_LAYOUTS = 4;
   localparam int LAYOUT_IW   = (NUM_LAYOUTS > 1) ? $clog2(NUM_LAYOUTS) : 1;

   localparam int RAW_W    = 32;
   localparam int STICK_W  = 8;
   localparam int RAMP_W   = 8;
   localparam int SET_W    = 2;
   localparam int SLOT_W   = 5;
   localparam int CSR_W    = 2;

   // Direction bits in the logical button word.
   localparam int BIT_UP    = 0;
   localparam int BIT_DOWN  = 1;
   localparam int BIT_LEFT  = 2;
   localparam int BIT_RIGHT = 3;

   // Bits injected by the stick and cleared when opposing directions meet.
   localparam logic [31:0] INJECT_DOWN  = 32'h42;
   localparam logic [31:0] INJECT_UP    = 32'h21;
   localparam logic [31:0] INJECT_RIGHT = 32'h8;
   localparam logic [31:0] INJECT_LEFT  = 32'h4;
   localparam logic [31:0] CLEAR_ON_UP    = 32'h42;
   localparam logic [31:0] CLEAR_ON_RIGHT = 32'h4;

   localparam int STICK_THRESHOLD = 63;
   localparam int RAMP_STEP       = 4;
   localparam int RAMP_MAX        = 127;
   localparam int RAMP_MIN        = -128;

   typedef enum logic {
      MODE_SAMPLE      = 1'b0,
      MODE_TABLE_WRITE = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                   mode;
      logic                       present;
      logic [RAW_W-1:0]           buttons;
      logic signed [STICK_W-1:0]  stick_x;
      logic signed [STICK_W-1:0]  stick_y;
      logic                       stick_inhibit;
      logic [SET_W-1:0]           table_set;
      logic [SLOT_W-1:0]          table_slot;
      logic [RAW_W-1:0]           table_mask;
   } req_type;

   typedef struct packed {
      logic [NUM_BUTTONS-1:0]     held;
      logic [NUM_BUTTONS-1:0]     pressed;
      logic [NUM_BUTTONS-1:0]     released;
      logic signed [RAMP_W-1:0]   ramp_x;
      logic signed [RAMP_W-1:0]   ramp_y;
   } rsp_type;

endpackage

/* src/gamepad_input_conditioner_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_unit: controller sample conditioner
// Remaps raw buttons through loadable mask tables, adds stick directions,
// resolves opposing directions, runs the x/y ramps and reports button edges.
//
//   channel | ports                          | direction | content
//   --------+--------------------------------+-----------+------------------
//   request | req_valid, req_stall, req_data | in        | sample/mask write
//   result  | rsp_valid, rsp_stall, rsp_data | out       | held, edges, ramps
//   config  | csr_we, csr_wdata              | in        | key_layout
//
// Results appear in the cycle after the request transfer, in the result register, and
// one item may be taken in every cycle unless the request side stalls. Mask writes
// produce no result. The request side stalls only while a result sits in the output
// register and the result side stalls. Reset clears the mask tables (through
// per-entry valid bits), edge state, ramps and key_layout; there is no clearing pass.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner_unit
   import gic_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   // Mask tables: one lane per logical button, each lane holding one mask per
   // layout and read at the single selected layout.
   logic [RAW_W-1:0]        mask_ff   [NUM_BUTTONS][NUM_LAYOUTS];
   logic [NUM_LAYOUTS-1:0]  mvalid_ff [NUM_BUTTONS];
   logic [NUM_LAYOUTS-1:0]  mvalid_in [NUM_BUTTONS];

   logic [CSR_W-1:0]          key_layout_ff, key_layout_in;
   logic [NUM_BUTTONS-1:0]    prev_held_ff, prev_held_in;
   logic [NUM_BUTTONS-1:0]    last_rel_ff, last_rel_in;
   logic signed [RAMP_W-1:0]  ramp_x_ff, ramp_x_in;
   logic signed [RAMP_W-1:0]  ramp_y_ff, ramp_y_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic                      accept;
   logic                      do_sample;
   logic                      do_write;
   logic                      write_hit;
   logic [LAYOUT_IW-1:0]      layout_sel;
   logic [LAYOUT_IW-1:0]      write_set;
   logic [NUM_BUTTONS-1:0]    remapped;
   logic [NUM_BUTTONS-1:0]    pad;
   logic signed [STICK_W:0]   neg_x;
   logic signed [STICK_W:0]   neg_y;
   logic signed [RAMP_W-1:0]  ramp_x_next;
   logic signed [RAMP_W-1:0]  ramp_y_next;

   function automatic logic [LAYOUT_IW-1:0] layout_index(input logic [CSR_W-1:0] k);
      logic [CSR_W:0] v;
      begin
         v = {1'b0, k};
         // key_layout is below four, so three subtractions always suffice.
         for (int s = 0; s < 3; s++) begin
            if (32'(v) >= NUM_LAYOUTS) begin
               v = v - (CSR_W+1)'(NUM_LAYOUTS);
            end
         end
         return LAYOUT_IW'(v);
      end
   endfunction

   function automatic logic signed [RAMP_W-1:0] ramp_next(
      input logic signed [RAMP_W-1:0] r,
      input logic                     plus,
      input logic                     minus
   );
      logic signed [RAMP_W+1:0] w;
      begin
         w = {{2{r[RAMP_W-1]}}, r};
         if (plus || minus) begin
            if (plus) begin
               w = (w >= 0) ? w + (RAMP_W+2)'(RAMP_STEP) : '0;
            end
            if (minus) begin
               w = (w <= 0) ? w - (RAMP_W+2)'(RAMP_STEP) : '0;
            end
            if (w > (RAMP_W+2)'(RAMP_MAX)) begin
               w = (RAMP_W+2)'(RAMP_MAX);
            end
            if (w < $signed((RAMP_W+2)'(RAMP_MIN))) begin
               w = (RAMP_W+2)'(RAMP_MIN);
            end
         end else begin
            // Halve, rounding towards zero.
            w = (w + {{(RAMP_W+1){1'b0}}, w[RAMP_W+1]}) >>> 1;
         end
         return w[RAMP_W-1:0];
      end
   endfunction

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign do_sample = accept && (req_data.mode == MODE_SAMPLE);
   assign do_write  = accept && (req_data.mode == MODE_TABLE_WRITE);
   assign write_hit = do_write
                      && (32'(req_data.table_set) < NUM_LAYOUTS)
                      && (32'(req_data.table_slot) < NUM_BUTTONS);
   assign write_set  = LAYOUT_IW'(req_data.table_set);
   assign layout_sel = layout_index(key_layout_ff);

   assign key_layout_in = csr_we ? csr_wdata : key_layout_ff;

   always_comb begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         mvalid_in[b] = mvalid_ff[b];
         if (write_hit && (32'(req_data.table_slot) == b)) begin
            mvalid_in[b][write_set] = 1'b1;
         end
      end
   end

   always_comb begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         remapped[b] = mvalid_ff[b][layout_sel]
                       && ((req_data.buttons & mask_ff[b][layout_sel]) != '0);
      end
   end

   assign neg_x = -{req_data.stick_x[STICK_W-1], req_data.stick_x};
   assign neg_y = -{req_data.stick_y[STICK_W-1], req_data.stick_y};

   always_comb begin
      pad = remapped;
      if (!req_data.stick_inhibit) begin
         if (neg_y > (STICK_W+1)'(STICK_THRESHOLD)) begin
            pad = pad | INJECT_DOWN[NUM_BUTTONS-1:0];
         end
         if (neg_y < -(STICK_W+1)'(STICK_THRESHOLD)) begin
            pad = pad | INJECT_UP[NUM_BUTTONS-1:0];
         end
         if (neg_x > (STICK_W+1)'(STICK_THRESHOLD)) begin
            pad = pad | INJECT_RIGHT[NUM_BUTTONS-1:0];
         end
         if (neg_x < -(STICK_W+1)'(STICK_THRESHOLD)) begin
            pad = pad | INJECT_LEFT[NUM_BUTTONS-1:0];
         end
      end
      if (pad[BIT_UP]) begin
         pad = pad & ~CLEAR_ON_UP[NUM_BUTTONS-1:0];
      end
      if (pad[BIT_RIGHT]) begin
         pad = pad & ~CLEAR_ON_RIGHT[NUM_BUTTONS-1:0];
      end
   end

   assign ramp_x_next = ramp_next(ramp_x_ff, pad[BIT_RIGHT], pad[BIT_LEFT]);
   assign ramp_y_next = ramp_next(ramp_y_ff, pad[BIT_DOWN], pad[BIT_UP]);

   always_comb begin
      prev_held_in = prev_held_ff;
      last_rel_in  = last_rel_ff;
      ramp_x_in    = ramp_x_ff;
      ramp_y_in    = ramp_y_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (do_sample) begin
         rsp_valid_in = 1'b1;
         if (req_data.present) begin
            prev_held_in         = pad;
            last_rel_in          = prev_held_ff & ~pad;
            ramp_x_in            = ramp_x_next;
            ramp_y_in            = ramp_y_next;
            rsp_data_in.held     = pad;
            rsp_data_in.pressed  = pad & ~prev_held_ff;
            rsp_data_in.released = prev_held_ff & ~pad;
            rsp_data_in.ramp_x   = ramp_x_next;
            rsp_data_in.ramp_y   = ramp_y_next;
         end else begin
            // No controller: nothing is held or pressed, the last release is repeated.
            prev_held_in         = '0;
            rsp_data_in.held     = '0;
            rsp_data_in.pressed  = '0;
            rsp_data_in.released = last_rel_ff;
            rsp_data_in.ramp_x   = ramp_x_ff;
            rsp_data_in.ramp_y   = ramp_y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_layout_ff <= '0;
         prev_held_ff  <= '0;
         last_rel_ff   <= '0;
         ramp_x_ff     <= '0;
         ramp_y_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            mvalid_ff[b] <= '0;
         end
      end else begin
         key_layout_ff <= key_layout_in;
         prev_held_ff  <= prev_held_in;
         last_rel_ff   <= last_rel_in;
         ramp_x_ff     <= ramp_x_in;
         ramp_y_ff     <= ramp_y_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            mvalid_ff[b] <= mvalid_in[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (write_hit) begin
         mask_ff[req_data.table_slot][write_set] <= req_data.table_mask;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A button cannot both go down and come up within one sample.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.pressed & rsp_data_ff.released) == '0))
      else $error("pressed and released overlap");

   // Opposing directions are always resolved in the held word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.held[BIT_UP] && rsp_data_ff.held[BIT_DOWN])
                       && !(rsp_data_ff.held[BIT_LEFT] && rsp_data_ff.held[BIT_RIGHT]))
      else $error("opposing directions both held");

   // A sample without a controller reports nothing held and keeps the ramps.
   assert property (@(posedge clock) disable iff (reset)
      (do_sample && !req_data.present) |=> rsp_valid_ff && (rsp_data_ff.held == '0)
         && (rsp_data_ff.pressed == '0) && $stable(ramp_x_ff) && $stable(ramp_y_ff))
      else $error("absent sample changed held state or ramps");

   // A mask write never creates a result of its own.
   assert property (@(posedge clock) disable iff (reset)
      (do_write && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("mask write produced a result");

   // Edge state is only disturbed by sample transfers.
   assert property (@(posedge clock) disable iff (reset)
      !do_sample |=> $stable(prev_held_ff) && $stable(last_rel_ff))
      else $error("edge state changed without a sample");

endmodule

/* verif/gamepad_input_conditioner_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_unit_test: self-checking bench for the conditioner
// A short table of hand-picked transfers opens the run, followed by phases of
// random traffic. Each phase selects a key layout and one of three patterns of
// sender gaps and receiver stalls. A behavioural copy of the conditioner predicts
// every result that the table does not pin, and each result is compared field by field.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner_unit_test;
   import gic_pkg::*;

   localparam int CYCLE_LIMIT     = 200_000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 250;

   typedef struct {
      req_type item;
      bit      pinned;
      rsp_type want;
   } stimulus_row;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we;
   logic [CSR_W-1:0] csr_wdata;

   // Behavioural copy of the conditioner state.
   logic [RAW_W-1:0]       remap_masks [NUM_LAYOUTS][NUM_BUTTONS] = '{default: '0};
   logic [NUM_BUTTONS-1:0] last_held      = '0;
   logic [NUM_BUTTONS-1:0] stale_released = '0;
   int                     ramp_x_now     = 0;
   int                     ramp_y_now     = 0;
   logic [CSR_W-1:0]       layout_sel     = '0;

   rsp_type     pending_results [$];
   stimulus_row directed_rows [$];
   bit          pin_armed;
   rsp_type     pin_value;
   int          send_gap_pct;
   int          recv_stall_pct;
   int          fail_count  = 0;
   int          cycle_count = 0;

   gamepad_input_conditioner_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int next_ramp(int r, bit toward_plus, bit toward_minus);
      if (!toward_plus && !toward_minus) return r / 2;
      if (toward_plus) r = (r >= 0) ? r + RAMP_STEP : 0;
      if (toward_minus) r = (r <= 0) ? r - RAMP_STEP : 0;
      if (r > RAMP_MAX) r = RAMP_MAX;
      if (r < RAMP_MIN) r = RAMP_MIN;
      return r;
   endfunction

   // Applies one accepted transfer to the state copy; returns 1 when it yields a result.
   function automatic bit condition_item(input req_type it, output rsp_type res);
      logic [31:0] pad;
      int          ax;
      int          ay;
      pad = '0;
      res = '0;
      if (it.mode == MODE_TABLE_WRITE) begin
         if (it.table_slot < NUM_BUTTONS) remap_masks[it.table_set][it.table_slot] = it.table_mask;
         return 1'b0;
      end
      if (!it.present) begin
         last_held    = '0;
         res.released = stale_released;
         res.ramp_x   = ramp_x_now[RAMP_W-1:0];
         res.ramp_y   = ramp_y_now[RAMP_W-1:0];
         return 1'b1;
      end
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if ((it.buttons & remap_masks[layout_sel % NUM_LAYOUTS][i]) != 0) pad[i] = 1'b1;
      end
      // The stick is negated before thresholding, so full negative deflection reads +128.
      ax = -int'($signed(it.stick_x));
      ay = -int'($signed(it.stick_y));
      if (!it.stick_inhibit) begin
         if (ay > STICK_THRESHOLD) pad |= INJECT_DOWN;
         if (ay < -STICK_THRESHOLD) pad |= INJECT_UP;
         if (ax > STICK_THRESHOLD) pad |= INJECT_RIGHT;
         if (ax < -STICK_THRESHOLD) pad |= INJECT_LEFT;
      end
      if (pad[BIT_UP]) pad &= ~CLEAR_ON_UP;
      if (pad[BIT_RIGHT]) pad &= ~CLEAR_ON_RIGHT;
      ramp_x_now = next_ramp(ramp_x_now, pad[BIT_RIGHT], pad[BIT_LEFT]);
      ramp_y_now = next_ramp(ramp_y_now, pad[BIT_DOWN], pad[BIT_UP]);
      res.held       = pad[NUM_BUTTONS-1:0];
      res.pressed    = res.held & ~last_held;
      res.released   = last_held & ~res.held;
      res.ramp_x     = ramp_x_now[RAMP_W-1:0];
      res.ramp_y     = ramp_y_now[RAMP_W-1:0];
      stale_released = res.released;
      last_held      = res.held;
      return 1'b1;
   endfunction

   function automatic void add_row(mode_type m, bit present, logic [31:0] buttons,
                                   int sx, int sy, bit inhibit, int set, int slot,
                                   logic [31:0] mask, bit pinned,
                                   logic [NUM_BUTTONS-1:0] held,
                                   logic [NUM_BUTTONS-1:0] pressed,
                                   logic [NUM_BUTTONS-1:0] released, int rx, int ry);
      stimulus_row r;
      r.item.mode          = m;
      r.item.present       = present;
      r.item.buttons       = buttons;
      r.item.stick_x       = sx[STICK_W-1:0];
      r.item.stick_y       = sy[STICK_W-1:0];
      r.item.stick_inhibit = inhibit;
      r.item.table_set     = set[SET_W-1:0];
      r.item.table_slot    = slot[SLOT_W-1:0];
      r.item.table_mask    = mask;
      r.pinned             = pinned;
      r.want.held          = held;
      r.want.pressed       = pressed;
      r.want.released      = released;
      r.want.ramp_x        = rx[RAMP_W-1:0];
      r.want.ramp_y        = ry[RAMP_W-1:0];
      directed_rows.push_back(r);
   endfunction

   // Stick positions cluster around the thresholds and the two extremes.
   function automatic logic [STICK_W-1:0] pick_stick();
      case ($urandom_range(7))
         0: return 8'h80;
         1: return 8'h7F;
         2: return 8'hC0;
         3: return 8'hC1;
         4: return 8'h3F;
         5: return 8'h40;
         6: return 8'h00;
         default: return STICK_W'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected result", got.held, 0);
         return;
      end
      want = pending_results.pop_front();
      if (got.held !== want.held) report_mismatch("held", got.held, want.held);
      if (got.pressed !== want.pressed) report_mismatch("pressed", got.pressed, want.pressed);
      if (got.released !== want.released)
         report_mismatch("released", got.released, want.released);
      if (got.ramp_x !== want.ramp_x) report_mismatch("ramp_x", got.ramp_x, want.ramp_x);
      if (got.ramp_y !== want.ramp_y) report_mismatch("ramp_y", got.ramp_y, want.ramp_y);
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input req_type it, input bit pinned, input rsp_type want);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      pin_armed = pinned;
      pin_value = want;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      while (pending_results.size() != 0) @(negedge clock);
      // Mask writes yield nothing, so allow the pipeline a little longer to settle.
      repeat (2) @(negedge clock);
   endtask

   always @(posedge clock) begin : watch
      rsp_type predicted;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (csr_we) layout_sel = csr_wdata;
         if (req_valid && !req_stall) begin
            if (condition_item(req_data, predicted))
               pending_results.push_back(pin_armed ? pin_value : predicted);
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      req_type          it;
      rsp_type          none;
      int               kind;
      logic [RAW_W-1:0] hold_buttons;
      logic [7:0]       hold_sx;
      logic [7:0]       hold_sy;
      bit               hold_inhibit;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      pin_armed      = 1'b0;
      pin_value      = '0;
      none           = '0;
      send_gap_pct   = 9;
      recv_stall_pct = 55;
      hold_buttons   = '0;
      hold_sx        = '0;
      hold_sy        = '0;
      hold_inhibit   = 1'b0;

      // After reset every mask is clear, so only the stick can raise buttons.
      add_row(MODE_SAMPLE, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1, 'h0, 'h0, 'h0, 0, 0);
      add_row(MODE_SAMPLE, 1, 0, -128, 0, 0, 0, 0, 0, 1, 'h8, 'h8, 'h0, 4, 0);
      add_row(MODE_SAMPLE, 1, 0, 127, 0, 0, 0, 0, 0, 1, 'h4, 'h4, 'h8, 0, 0);
      add_row(MODE_SAMPLE, 1, 0, 0, -128, 0, 0, 0, 0, 1, 'h42, 'h42, 'h4, 0, 4);
      add_row(MODE_SAMPLE, 1, 0, 0, 127, 0, 0, 0, 0, 1, 'h21, 'h21, 'h42, 0, 0);
      // A missing controller repeats the last released word and keeps the ramps.
      add_row(MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 'h0, 'h0, 'h42, 0, 0);
      add_row(MODE_SAMPLE, 0, 32'hFFFF_FFFF, -128, -128, 0, 3, 31, 0, 1,
              'h0, 'h0, 'h42, 0, 0);
      add_row(MODE_SAMPLE, 1, 0, -128, 0, 1, 0, 0, 0, 1, 'h0, 'h0, 'h0, 0, 0);
      add_row(MODE_TABLE_WRITE, 0, 32'hFFFF_FFFF, -128, 127, 1, 0, 0, 32'h1, 0, 0, 0, 0, 0, 0);
      add_row(MODE_TABLE_WRITE, 1, 0, 0, 0, 0, 0, 1, 32'h2, 0, 0, 0, 0, 0, 0);
      add_row(MODE_TABLE_WRITE, 1, 0, 0, 0, 0, 0, 2, 32'h4, 0, 0, 0, 0, 0, 0);
      add_row(MODE_TABLE_WRITE, 1, 0, 0, 0, 0, 0, 3, 32'h8, 0, 0, 0, 0, 0, 0);
      add_row(MODE_TABLE_WRITE, 1, 0, 0, 0, 0, 0, 17, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
      // Slots past the last button must leave the tables untouched.
      add_row(MODE_TABLE_WRITE, 1, 0, 0, 0, 0, 0, 18, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
      add_row(MODE_TABLE_WRITE, 1, 0, 0, 0, 0, 0, 31, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
      add_row(MODE_TABLE_WRITE, 1, 0, 0, 0, 0, 3, 16, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
      // Opposing directions from the buttons, the top button, and button against stick.
      add_row(MODE_SAMPLE, 1, 32'h3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_SAMPLE, 1, 32'hC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_SAMPLE, 1, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_SAMPLE, 1, 32'hFFFF_FFFF, -128, -128, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_SAMPLE, 1, 32'h1, 0, -128, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_SAMPLE, 0, 32'h1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // Just past and just short of the threshold on each axis.
      add_row(MODE_SAMPLE, 1, 0, -64, -63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_SAMPLE, 1, 0, 63, 64, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].want);

      for (int phase = 0; phase < PHASES; phase++) begin
         // The layout may only change once the block has gone quiet.
         req_valid <= 1'b0;
         wait_for_results();
         csr_we    <= 1'b1;
         csr_wdata <= CSR_W'(3 - phase % 4);
         @(negedge clock);
         csr_we <= 1'b0;
         if (phase < 3) begin
            send_gap_pct   = 9;
            recv_stall_pct = 55;
         end else if (phase < 6) begin
            send_gap_pct   = 55;
            recv_stall_pct = 9;
         end else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end

         repeat (ITEMS_PER_PHASE) begin
            it.mode          = MODE_SAMPLE;
            it.present       = 1'b1;
            it.buttons       = $urandom;
            it.stick_x       = STICK_W'($urandom);
            it.stick_y       = STICK_W'($urandom);
            it.stick_inhibit = 1'($urandom);
            it.table_set     = SET_W'($urandom);
            it.table_slot    = SLOT_W'($urandom);
            it.table_mask    = $urandom;
            kind = $urandom_range(99);
            if (kind < 10) begin
               it.mode = MODE_TABLE_WRITE;
               if ($urandom_range(3) != 0)
                  it.table_slot = SLOT_W'($urandom_range(NUM_BUTTONS - 1));
               case ($urandom_range(4))
                  0: it.table_mask = 32'h1 << $urandom_range(31);
                  1: it.table_mask = '0;
                  2: it.table_mask = '1;
                  3: it.table_mask = $urandom & $urandom;
                  default: ;
               endcase
            end else begin
               // Inputs are held for runs of samples so that the ramps can saturate.
               if ($urandom_range(31) == 0) begin
                  hold_sx = pick_stick();
                  hold_sy = pick_stick();
               end
               if ($urandom_range(7) == 0) begin
                  case ($urandom_range(3))
                     0: hold_buttons = $urandom & $urandom & $urandom;
                     1: hold_buttons = 32'h1 << $urandom_range(31);
                     2: hold_buttons = '0;
                     default: hold_buttons = $urandom;
                  endcase
               end
               if ($urandom_range(15) == 0) hold_inhibit = ($urandom_range(3) == 0);
               it.present       = (kind >= 15);
               it.buttons       = hold_buttons;
               it.stick_x       = hold_sx;
               it.stick_y       = hold_sy;
               it.stick_inhibit = hold_inhibit;
            end
            send_item(it, 1'b0, none);
         end
      end

      req_valid <= 1'b0;
      wait_for_results();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
